>>> src/rmva_pkg.sv
// ============================================================================
// rmva_pkg
// shared types, constants and arithmetic helpers of the running mean and
// variance accumulator
// ============================================================================
package rmva_pkg;

    // fixed point format and state widths
    localparam int FRAC_BITS = 16;
    localparam int CNT_W     = 32;
    localparam int MEAN_W    = 48;
    localparam int M2_W      = 64;
    localparam int SD_W      = 48;
    localparam int ROOT_W    = 40;
    localparam int RAD_W     = 80;
    localparam int SREM_W    = 43;

    localparam logic [CNT_W-1:0]  COUNT_MAX    = '1;
    localparam logic [63:0]       MEAN_MAX     = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0]       MEAN_MIN_MAG = 64'h0000_8000_0000_0000;

    // command codes carried in tuser
    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_SET   = 3'd1;
    localparam logic [2:0] CMD_ADD   = 3'd2;
    localparam logic [2:0] CMD_MERGE = 3'd3;
    localparam logic [2:0] CMD_MUL   = 3'd4;
    localparam logic [2:0] CMD_DIV   = 3'd5;

    // iteration counts of the shared units, minus one
    localparam int IT_W = 7;
    localparam logic [IT_W-1:0] IT_MUL  = IT_W'(64 - 1);
    localparam logic [IT_W-1:0] IT_DIV  = IT_W'(128 - 1);
    localparam logic [IT_W-1:0] IT_SQRT = IT_W'(ROOT_W - 1);

    // micro steps of the sequencer
    typedef enum logic [4:0] {
        S_CLEAR,
        S_SET,
        S_ADD_PREP,
        S_ADD_DIV,
        S_ADD_MUL,
        S_MRG_PREP,
        S_MRG_MV_MUL,
        S_MRG_MV_DIV,
        S_MRG_SQ_MUL,
        S_MRG_N_MUL,
        S_MRG_T_MUL,
        S_MRG_T_DIV,
        S_SCL_MEAN,
        S_SCL_M2,
        S_DIV_ERR,
        S_DIV_MEAN,
        S_DIV_M2,
        S_VAR_DIV,
        S_SQRT
    } t_step;

    typedef enum logic [1:0] {
        U_NONE,
        U_MUL,
        U_DIV,
        U_SQRT
    } t_unit;

    // controller to datapath
    typedef struct packed {
        logic  cap;
        logic  go;
        logic  wr;
        logic  load;
        t_step step;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic       busy;
        logic       out_free;
        logic [2:0] cmd;
        logic       nb_zero;
        logic       sv_zero;
    } t_sts;

    // which shared unit a step runs on
    function automatic t_unit f_unit(input t_step step);
        t_unit u;
        unique case (step)
            S_ADD_MUL, S_MRG_MV_MUL, S_MRG_SQ_MUL, S_MRG_N_MUL, S_MRG_T_MUL,
            S_SCL_MEAN, S_SCL_M2:                          u = U_MUL;
            S_ADD_DIV, S_MRG_MV_DIV, S_MRG_T_DIV, S_DIV_MEAN, S_DIV_M2,
            S_VAR_DIV:                                     u = U_DIV;
            S_SQRT:                                        u = U_SQRT;
            default:                                       u = U_NONE;
        endcase
        return u;
    endfunction

    // magnitude of a two's complement word
    function automatic logic [63:0] f_mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // saturate a 128-bit value to 64 bits
    function automatic logic [63:0] f_sat64(input logic [127:0] v);
        return (|v[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : v[63:0];
    endfunction

    // saturating unsigned add
    function automatic logic [63:0] f_add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    // signed 48-bit saturation from sign and magnitude
    function automatic logic [MEAN_W-1:0] f_sat48(input logic neg, input logic [63:0] m);
        logic [63:0] t;
        t = 64'd0 - m;
        if (neg) begin
            return (m >= MEAN_MIN_MAG) ? MEAN_MIN_MAG[MEAN_W-1:0] : t[MEAN_W-1:0];
        end
        return (m > MEAN_MAX) ? MEAN_MAX[MEAN_W-1:0] : m[MEAN_W-1:0];
    endfunction

endpackage

>>> src/rmva_ctrl.sv
// ============================================================================
// rmva_ctrl
// sequencer: takes a word, walks the micro steps of its command over the
// shared units, then hands the result to the output register
// ============================================================================
module rmva_ctrl
    import rmva_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_GO,
        ST_WAIT,
        ST_WR,
        ST_OUT
    } t_state;

    t_state r_state, n_state;
    t_step  r_step, n_step;
    t_step  w_first;
    t_step  w_next;

    // step after a given one
    function automatic t_step f_next(input t_step s);
        t_step n;
        unique case (s)
            S_CLEAR, S_SET, S_ADD_MUL, S_MRG_T_DIV, S_SCL_M2, S_DIV_ERR,
            S_DIV_M2:     n = S_VAR_DIV;
            S_ADD_PREP:   n = S_ADD_DIV;
            S_ADD_DIV:    n = S_ADD_MUL;
            S_MRG_PREP:   n = S_MRG_MV_MUL;
            S_MRG_MV_MUL: n = S_MRG_MV_DIV;
            S_MRG_MV_DIV: n = S_MRG_SQ_MUL;
            S_MRG_SQ_MUL: n = S_MRG_N_MUL;
            S_MRG_N_MUL:  n = S_MRG_T_MUL;
            S_MRG_T_MUL:  n = S_MRG_T_DIV;
            S_SCL_MEAN:   n = S_SCL_M2;
            S_DIV_MEAN:   n = S_DIV_M2;
            S_VAR_DIV:    n = S_SQRT;
            default:      n = S_SQRT;
        endcase
        return n;
    endfunction

    // first step of the captured command
    always_comb begin
        unique case (i_sts.cmd)
            CMD_CLEAR: w_first = S_CLEAR;
            CMD_SET:   w_first = S_SET;
            CMD_ADD:   w_first = S_ADD_PREP;
            CMD_MERGE: w_first = i_sts.nb_zero ? S_VAR_DIV : S_MRG_PREP;
            CMD_MUL:   w_first = S_SCL_MEAN;
            CMD_DIV:   w_first = i_sts.sv_zero ? S_DIV_ERR : S_DIV_MEAN;
            default:   w_first = S_VAR_DIV;
        endcase
    end

    assign w_next = f_next(r_step);

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                n_step  = w_first;
                n_state = (f_unit(w_first) == U_NONE) ? ST_WR : ST_GO;
            end
            ST_GO: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (!i_sts.busy) n_state = ST_WR;
            end
            ST_WR: begin
                if (r_step == S_SQRT) begin
                    n_state = ST_OUT;
                end else begin
                    n_step  = w_next;
                    n_state = (f_unit(w_next) == U_NONE) ? ST_WR : ST_GO;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state and step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= S_CLEAR;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // commands to the datapath
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_ctl.cap  = (r_state == ST_IDLE) && i_s_tvalid;
    assign o_ctl.go   = (r_state == ST_GO);
    assign o_ctl.wr   = (r_state == ST_WR);
    assign o_ctl.load = (r_state == ST_OUT) && i_sts.out_free;
    assign o_ctl.step = r_step;

endmodule

>>> src/rmva_dp.sv
// ============================================================================
// rmva_dp
// datapath: accumulator state, scratch registers, shared shift-add multiplier,
// restoring divider and square root unit, output register
// ============================================================================
module rmva_dp
    import rmva_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ctl         i_ctl,
    output t_sts         o_sts,
    input  logic [159:0] i_s_tdata,
    input  logic [2:0]   i_s_tuser,
    input  logic         i_m_tready,
    output logic         o_m_tvalid,
    output logic [175:0] o_m_tdata,
    output logic         o_m_tuser
);

    // captured word
    logic [2:0]        r_cmd;
    logic [31:0]       r_sv;
    logic [31:0]       r_onb;
    logic [31:0]       r_om;
    logic [63:0]       r_om2;

    // accumulator state
    logic [CNT_W-1:0]  r_cnt;
    logic [MEAN_W-1:0] r_mean;
    logic [M2_W-1:0]   r_m2;
    logic              r_err;

    // scratch
    logic [63:0]       r_d;
    logic [63:0]       r_nm;
    logic [63:0]       r_t;
    logic [63:0]       r_u;
    logic [CNT_W:0]    r_tot;
    logic [63:0]       r_var;
    logic [ROOT_W-1:0] r_sd;

    // shared units
    logic              r_busy;
    t_unit             r_kind;
    logic [IT_W-1:0]   r_it;
    logic [63:0]       r_ma;
    logic [127:0]      r_mp;
    logic [63:0]       r_dd;
    logic [127:0]      r_dq;
    logic [63:0]       r_dr;
    logic [RAD_W-1:0]  r_sx;
    logic [SREM_W-1:0] r_srem;
    logic [ROOT_W-1:0] r_sroot;

    // output register
    logic              r_ovalid;
    logic [31:0]       r_ocnt;
    logic [31:0]       r_omean;
    logic [63:0]       r_ovar;
    logic [SD_W-1:0]   r_osd;
    logic              r_oerr;

    logic [63:0]       w_sx;
    logic [63:0]       w_mean64;
    logic [63:0]       w_fm;
    logic [63:0]       w_dmag;
    logic [63:0]       w_mmag;
    logic [63:0]       w_amag;
    logic [63:0]       w_quot;
    logic [63:0]       w_psat;
    logic [63:0]       w_ma_in;
    logic [63:0]       w_mb_in;
    logic [127:0]      w_dn_in;
    logic [63:0]       w_dd_in;
    logic [64:0]       w_msum;
    logic [64:0]       w_drs;
    logic              w_dge;
    logic [SREM_W+1:0] w_stmp;
    logic [SREM_W+1:0] w_strial;
    logic              w_sge;
    logic [31:0]       w_mclamp;
    logic              w_cnt_ge2;

    // common operand views
    assign w_sx      = {{32{r_sv[31]}}, r_sv};
    assign w_mean64  = {{(64-MEAN_W){r_mean[MEAN_W-1]}}, r_mean};
    assign w_fm      = f_mag(w_sx);
    assign w_dmag    = f_mag(r_d);
    assign w_mmag    = f_mag(w_mean64);
    assign w_amag    = f_mag(w_sx - r_nm);
    assign w_quot    = f_sat64(r_dq);
    assign w_psat    = f_sat64(r_mp >> FRAC_BITS);
    assign w_cnt_ge2 = (r_cnt >= CNT_W'(2));

    // operand select for the unit a step starts
    always_comb begin
        w_ma_in = w_dmag;
        w_mb_in = w_dmag;
        w_dn_in = {64'd0, r_m2};
        w_dd_in = w_cnt_ge2 ? 64'(r_cnt - 1'b1) : 64'd1;
        case (i_ctl.step)
            S_ADD_DIV: begin
                w_dn_in = {64'd0, w_dmag};
                w_dd_in = 64'(r_cnt);
            end
            S_ADD_MUL: begin
                w_mb_in = w_amag;
            end
            S_MRG_MV_MUL: begin
                w_mb_in = 64'(r_onb);
            end
            S_MRG_MV_DIV, S_MRG_T_DIV: begin
                w_dn_in = r_mp;
                w_dd_in = 64'(r_tot);
            end
            S_MRG_N_MUL: begin
                w_ma_in = 64'(r_cnt);
                w_mb_in = 64'(r_onb);
            end
            S_MRG_T_MUL: begin
                w_ma_in = r_t;
                w_mb_in = r_u;
            end
            S_SCL_MEAN: begin
                w_ma_in = w_mmag;
                w_mb_in = w_fm;
            end
            S_SCL_M2: begin
                w_ma_in = r_m2;
                w_mb_in = w_fm;
            end
            S_DIV_MEAN: begin
                w_dn_in = 128'(w_mmag) << FRAC_BITS;
                w_dd_in = w_fm;
            end
            S_DIV_M2: begin
                w_dn_in = 128'(r_m2) << FRAC_BITS;
                w_dd_in = w_fm;
            end
            default: begin
            end
        endcase
    end

    // one iteration of each unit
    assign w_msum   = {1'b0, r_mp[127:64]} + (r_mp[0] ? {1'b0, r_ma} : 65'd0);
    assign w_drs    = {r_dr, r_dq[127]};
    assign w_dge    = (w_drs >= {1'b0, r_dd});
    assign w_stmp   = {r_srem, r_sx[RAD_W-1:RAD_W-2]};
    assign w_strial = (SREM_W+2)'({r_sroot, 2'b01});
    assign w_sge    = (w_stmp >= w_strial);

    // shared units
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_kind <= U_NONE;
        end else if (i_ctl.go) begin
            r_busy <= 1'b1;
            r_kind <= f_unit(i_ctl.step);
            case (f_unit(i_ctl.step))
                U_MUL: begin
                    r_it <= IT_MUL;
                    r_ma <= w_ma_in;
                    r_mp <= {64'd0, w_mb_in};
                end
                U_DIV: begin
                    r_it <= IT_DIV;
                    r_dq <= w_dn_in;
                    r_dd <= w_dd_in;
                    r_dr <= 64'd0;
                end
                default: begin
                    r_it    <= IT_SQRT;
                    r_sx    <= {r_var, FRAC_BITS'(0)};
                    r_srem  <= '0;
                    r_sroot <= '0;
                end
            endcase
        end else if (r_busy) begin
            r_it <= r_it - 1'b1;
            if (r_it == '0) r_busy <= 1'b0;
            case (r_kind)
                U_MUL: begin
                    r_mp <= {w_msum, r_mp[63:1]};
                end
                U_DIV: begin
                    r_dr <= w_dge ? 64'(w_drs - {1'b0, r_dd}) : w_drs[63:0];
                    r_dq <= {r_dq[126:0], w_dge};
                end
                default: begin
                    r_srem  <= w_sge ? SREM_W'(w_stmp - w_strial) : w_stmp[SREM_W-1:0];
                    r_sroot <= {r_sroot[ROOT_W-2:0], w_sge};
                    r_sx    <= {r_sx[RAD_W-3:0], 2'b00};
                end
            endcase
        end
    end

    // input capture and step write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_mean <= '0;
            r_m2   <= '0;
            r_err  <= 1'b0;
            r_cmd  <= CMD_CLEAR;
        end else if (i_ctl.cap) begin
            r_cmd <= i_s_tuser;
            r_sv  <= i_s_tdata[31:0];
            r_onb <= i_s_tdata[63:32];
            r_om  <= i_s_tdata[95:64];
            r_om2 <= i_s_tdata[159:96];
            r_err <= 1'b0;
        end else if (i_ctl.wr) begin
            case (i_ctl.step)
                S_CLEAR: begin
                    r_cnt  <= '0;
                    r_mean <= '0;
                    r_m2   <= '0;
                end
                S_SET: begin
                    r_cnt  <= CNT_W'(1);
                    r_mean <= w_sx[MEAN_W-1:0];
                    r_m2   <= '0;
                end
                S_ADD_PREP: begin
                    r_cnt <= (r_cnt == COUNT_MAX) ? r_cnt : r_cnt + 1'b1;
                    r_d   <= w_sx - w_mean64;
                end
                S_ADD_DIV, S_MRG_MV_DIV: begin
                    r_nm <= r_d[63] ? (w_mean64 - r_dq[63:0]) : (w_mean64 + r_dq[63:0]);
                end
                S_ADD_MUL: begin
                    r_m2   <= f_add_sat(r_m2, w_psat);
                    r_mean <= r_nm[MEAN_W-1:0];
                end
                S_MRG_PREP: begin
                    r_tot <= {1'b0, r_cnt} + (CNT_W+1)'(r_onb);
                    r_d   <= {{32{r_om[31]}}, r_om} - w_mean64;
                end
                S_MRG_SQ_MUL: begin
                    r_t <= w_psat;
                end
                S_MRG_N_MUL: begin
                    r_u <= r_mp[63:0];
                end
                S_MRG_T_DIV: begin
                    r_m2   <= f_add_sat(f_add_sat(r_m2, r_om2), w_quot);
                    r_mean <= r_nm[MEAN_W-1:0];
                    r_cnt  <= r_tot[CNT_W] ? COUNT_MAX : r_tot[CNT_W-1:0];
                end
                S_SCL_MEAN: begin
                    r_mean <= f_sat48((r_mean[MEAN_W-1] != r_sv[31]) && (r_mean != '0)
                                      && (r_sv != 32'd0), w_psat);
                end
                S_SCL_M2: begin
                    r_m2 <= r_sv[31] ? '0 : w_psat;
                end
                S_DIV_ERR: begin
                    r_err <= 1'b1;
                end
                S_DIV_MEAN: begin
                    r_mean <= f_sat48((r_mean[MEAN_W-1] != r_sv[31]) && (w_quot != 64'd0),
                                      w_quot);
                end
                S_DIV_M2: begin
                    r_m2 <= r_sv[31] ? '0 : w_quot;
                end
                S_VAR_DIV: begin
                    r_var <= w_cnt_ge2 ? r_dq[63:0] : 64'd0;
                end
                S_SQRT: begin
                    r_sd <= r_sroot;
                end
                default: begin
                end
            endcase
        end
    end

    // mean clamped to q16.16
    always_comb begin
        if (!r_mean[MEAN_W-1] && (|r_mean[MEAN_W-2:31])) begin
            w_mclamp = 32'h7FFF_FFFF;
        end else if (r_mean[MEAN_W-1] && !(&r_mean[MEAN_W-2:31])) begin
            w_mclamp = 32'h8000_0000;
        end else begin
            w_mclamp = r_mean[31:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.load) begin
            r_ovalid <= 1'b1;
            r_ocnt   <= 32'(r_cnt);
            r_omean  <= w_mclamp;
            r_ovar   <= r_var;
            r_osd    <= SD_W'(r_sd);
            r_oerr   <= r_err;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {r_osd, r_ovar, r_omean, r_ocnt};
    assign o_m_tuser  = r_oerr;

    assign o_sts.busy     = r_busy;
    assign o_sts.out_free = !r_ovalid || i_m_tready;
    assign o_sts.cmd      = r_cmd;
    assign o_sts.nb_zero  = (r_onb == 32'd0);
    assign o_sts.sv_zero  = (r_sv == 32'd0);

endmodule

>>> src/running_mean_variance_accumulator_core.sv
// one word at a time; clear, set, unknown command and divide by zero words are
// the shortest, add and divide take longer and merge takes the longest; the
// time is set by the shared 1-bit-per-cycle units for multiply, divide and
// square root, plus the sequencing steps between them
// a finished result waits in the output register while the next word is taken
// synchronous active-low reset clears count, mean, m2 and all control state
// ============================================================================
// running_mean_variance_accumulator_core
// running count, mean and sum of squared deviations with add, merge, scale
// and divide commands; reports count, mean, variance and standard deviation
// ============================================================================
module running_mean_variance_accumulator_core
    import rmva_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sample_value, other_count, other_mean, other_sq_dev_sum
    input  logic [159:0] s_axis_tdata,
    // command
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // sample_count, mean_out, variance_out, std_dev_out
    output logic [175:0] m_axis_tdata,
    // error_flag
    output logic         m_axis_tuser
);

    t_ctl w_ctl;
    t_sts w_sts;

    // sequencer
    rmva_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    // arithmetic and state
    rmva_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .o_sts      (w_sts),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

    // one word in flight: no new word right after one is taken
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("word taken while another is in work");

    // error flag only comes from a divide command
    a_err_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load |=> (!m_axis_tuser || ($past(w_sts.cmd) == CMD_DIV)))
        else $error("error flag on a command other than divide");

    // variance is zero below two samples
    a_var_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[31:0] < 32'd2)) |-> (m_axis_tdata[127:64] == 64'd0))
        else $error("nonzero variance with fewer than two samples");

    // no unit runs while a result is being loaded
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load |-> !w_sts.busy)
        else $error("result loaded while a unit is busy");

endmodule

>>> tb/running_mean_variance_accumulator_core_test.sv
`timescale 1ns / 100ps
// ============================================================================
// running_mean_variance_accumulator_core_test
// drives clear, set, add, merge, scale and divide commands into the
// accumulator, predicts count, mean, variance and standard deviation in the
// testbench, and compares every output word in order under random idling
// ============================================================================
module running_mean_variance_accumulator_core_test
    import rmva_pkg::*;
();

    // ------------------------------------------------------------------------
    // predictor of the accumulator with a queue of expected status words
    // ------------------------------------------------------------------------
    class stats_scoreboard;
        logic [31:0]  cnt;
        logic [63:0]  mean;      // signed, kept inside 48-bit limits
        logic [63:0]  m2;
        logic [176:0] pending[$];
        int           errors;
        int           checked;

        function new();
            cnt = '0; mean = '0; m2 = '0; errors = 0; checked = 0;
        endfunction

        function logic [63:0] sx32(input logic [31:0] v);
            return {{32{v[31]}}, v};
        endfunction

        function logic [63:0] sat_mean(input logic neg, input logic [63:0] m);
            if (neg) return (m >= MEAN_MIN_MAG) ? (64'd0 - MEAN_MIN_MAG) : (64'd0 - m);
            return (m > MEAN_MAX) ? MEAN_MAX : m;
        endfunction

        function logic [63:0] floor_root(input logic [63:0] v);
            logic [127:0] target;
            logic [63:0]  r, t;
            target = {64'd0, v} << FRAC_BITS;
            r = 0;
            for (int b = 48; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if ({64'd0, t} * {64'd0, t} <= target) r = t;
            end
            return r & 64'hFFFF_FFFF_FFFF;
        endfunction

        function void note_command(input logic [2:0] cmd, input logic [159:0] d);
            logic [63:0]  sv, om, delta, newm, dm, q, dsq, fm, mq;
            logic [127:0] p;
            logic [63:0]  ob, tot, var_q;
            logic         err;
            logic [63:0]  mo;
            logic [63:0]  sd;
            sv = sx32(d[31:0]);
            ob = {32'd0, d[63:32]};
            om = sx32(d[95:64]);
            err = 0;
            case (cmd)
                CMD_CLEAR: begin cnt = 0; mean = 0; m2 = 0; end
                CMD_SET: begin cnt = 1; mean = sv; m2 = 0; end
                CMD_ADD: begin
                    if (cnt != COUNT_MAX) cnt = cnt + 1;
                    delta = sv - mean;
                    q = f_mag(delta) / {32'd0, cnt};
                    newm = delta[63] ? mean - q : mean + q;
                    p = ({64'd0, f_mag(delta)} * {64'd0, f_mag(sv - newm)}) >> FRAC_BITS;
                    m2 = f_add_sat(m2, f_sat64(p));
                    mean = newm;
                end
                CMD_MERGE: if (ob != 0) begin
                    tot = {32'd0, cnt} + ob;
                    dm = om - mean;
                    p = ({64'd0, f_mag(dm)} * {64'd0, ob}) / {64'd0, tot};
                    q = f_sat64(p);
                    mean = dm[63] ? mean - q : mean + q;
                    dsq = f_sat64(({64'd0, f_mag(dm)} * {64'd0, f_mag(dm)}) >> FRAC_BITS);
                    p = ({64'd0, dsq} * {64'd0, {32'd0, cnt} * ob}) / {64'd0, tot};
                    m2 = f_add_sat(f_add_sat(m2, d[159:96]), f_sat64(p));
                    cnt = (tot > {32'd0, COUNT_MAX}) ? COUNT_MAX : tot[31:0];
                end
                CMD_MUL: begin
                    fm = f_mag(sv);
                    p = ({64'd0, f_mag(mean)} * {64'd0, fm}) >> FRAC_BITS;
                    mean = sat_mean((mean[63] != sv[63]) && mean != 0 && sv != 0, f_sat64(p));
                    m2 = sv[63] ? 64'd0
                        : f_sat64(({64'd0, m2} * {64'd0, fm}) >> FRAC_BITS);
                end
                CMD_DIV: begin
                    if (sv == 0) err = 1;
                    else begin
                        fm = f_mag(sv);
                        mq = f_sat64(({64'd0, f_mag(mean)} << FRAC_BITS) / {64'd0, fm});
                        mean = sat_mean((mean[63] != sv[63]) && mq != 0, mq);
                        m2 = sv[63] ? 64'd0
                            : f_sat64(({64'd0, m2} << FRAC_BITS) / {64'd0, fm});
                    end
                end
                default: ;
            endcase
            if ($signed(mean) > 64'sd2147483647) mo = 64'd2147483647;
            else if ($signed(mean) < -64'sd2147483648) mo = 64'hFFFF_FFFF_8000_0000;
            else mo = mean;
            var_q = (cnt >= 2) ? m2 / {32'd0, cnt - 32'd1} : 64'd0;
            sd = floor_root(var_q);
            pending.push_back({err, sd[47:0], var_q, mo[31:0], cnt});
        endfunction

        function void check_status(input logic [175:0] d, input logic e);
            logic [176:0] x;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected word %h", $time, d);
                return;
            end
            x = pending.pop_front();
            if (x[31:0] != d[31:0]) begin
                errors++;
                $display("%0t: count exp %h got %h", $time, x[31:0], d[31:0]);
            end
            if (x[63:32] != d[63:32]) begin
                errors++;
                $display("%0t: mean exp %h got %h", $time, x[63:32], d[63:32]);
            end
            if (x[127:64] != d[127:64]) begin
                errors++;
                $display("%0t: variance exp %h got %h", $time, x[127:64], d[127:64]);
            end
            if (x[175:128] != d[175:128]) begin
                errors++;
                $display("%0t: std dev exp %h got %h", $time, x[175:128], d[175:128]);
            end
            if (x[176] != e) begin
                errors++;
                $display("%0t: error flag exp %b got %b", $time, x[176], e);
            end
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata = '0;   // sample_value, other_count, other_mean, other_sq_dev_sum
    logic [2:0]   s_axis_tuser = '0;   // command
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [175:0] m_axis_tdata;        // sample_count, mean_out, variance_out, std_dev_out
    logic         m_axis_tuser;        // error_flag

    stats_scoreboard sb = new();
    int send_idle = 0;   // percent of cycles the sender idles
    int recv_idle = 0;   // percent of cycles the receiver stalls
    int sent = 0;
    int cmd_hits[8];

    running_mean_variance_accumulator_core i_dut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // receiver: sample at rising edge, change ready at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata, m_axis_tuser);
    end
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    // one word through the input handshake; valid is dropped by the next
    // idle cycle or by the drain wait, the block is busy in between
    task automatic send_word(input logic [2:0] cmd, input logic [31:0] sv,
                             input logic [31:0] oc, input logic [31:0] om,
                             input logic [63:0] om2);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {om2, om, oc, sv};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_command(cmd, {om2, om, oc, sv});
        cmd_hits[cmd]++;
        sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(32'h0010_0000);
            2: return -$urandom_range(32'h0010_0000);
            3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    task automatic random_word();
        logic [2:0]  cmd;
        logic [31:0] sv, oc;
        logic [63:0] om2;
        int k;
        k = $urandom_range(99);
        if (k < 4) cmd = CMD_CLEAR;
        else if (k < 12) cmd = CMD_SET;
        else if (k < 60) cmd = CMD_ADD;
        else if (k < 76) cmd = CMD_MERGE;
        else if (k < 86) cmd = CMD_MUL;
        else if (k < 96) cmd = CMD_DIV;
        else cmd = 3'($urandom_range(7));
        sv = rnd_val();
        if ((cmd == CMD_MUL || cmd == CMD_DIV) && $urandom_range(3) != 0)
            sv = $urandom_range(32'h0003_0000) - 32'h0001_8000;
        if (cmd == CMD_DIV && $urandom_range(15) == 0) sv = 0;
        case ($urandom_range(3))
            0: oc = $urandom;
            1: oc = 0;
            default: oc = $urandom_range(20);
        endcase
        om2 = $urandom_range(1) ? {$urandom, $urandom} : 64'($urandom);
        send_word(cmd, sv, oc, rnd_val(), om2);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // directed: extremes and special cases
        send_word(CMD_ADD, 32'h0001_0000, 0, 0, 0);
        send_word(CMD_ADD, 32'h7FFF_FFFF, 0, 0, 0);
        send_word(CMD_ADD, 32'h8000_0000, 0, 0, 0);
        send_word(CMD_DIV, 32'd0, 0, 0, 0);
        send_word(CMD_MUL, 32'h7FFF_FFFF, 0, 0, 0);
        send_word(CMD_MUL, 32'h7FFF_FFFF, 0, 0, 0);
        send_word(CMD_DIV, 32'h0000_0001, 0, 0, 0);
        send_word(CMD_DIV, 32'hFFFF_FFFF, 0, 0, 0);
        send_word(CMD_MUL, 32'hFFFF_0000, 0, 0, 0);
        send_word(CMD_MUL, 32'd0, 0, 0, 0);
        send_word(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
        send_word(3'd7, 0, 0, 0, 0);
        send_word(CMD_SET, 32'h8000_0000, 0, 0, 0);
        send_word(CMD_MERGE, 0, 32'd0, 32'h7FFF_FFFF, 64'd5);
        send_word(CMD_MERGE, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, '1);
        send_word(CMD_MERGE, 0, 32'hFFFF_FFFF, 32'h8000_0000, '1);
        send_word(CMD_ADD, 32'h0000_1234, 0, 0, 0);
        send_word(CMD_CLEAR, 0, 0, 0, 0);
        send_word(CMD_MERGE, 0, 32'd3, 32'h0002_0000, 64'h0003_0000);
        send_word(CMD_ADD, 32'hFFFF_0000, 0, 0, 0);
        send_word(CMD_DIV, 32'h0002_0000, 0, 0, 0);
        send_word(CMD_DIV, 32'hFFFE_0000, 0, 0, 0);
        send_word(CMD_CLEAR, 0, 0, 0, 0);
        // pause until every expected word is back
        wait_drained();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 74 : 18) : 0;
            recv_idle = (ph == 2) ? 74 : ((ph == 3) ? 18 : 0);
            repeat (370) random_word();
        end
        send_idle = 0;
        recv_idle = 0;
        wait_drained();
        repeat (800) @(negedge i_clk);
        $display("sent %0d words (clear %0d set %0d add %0d merge %0d mul %0d div %0d other %0d)",
                 sent, cmd_hits[0], cmd_hits[1], cmd_hits[2], cmd_hits[3],
                 cmd_hits[4], cmd_hits[5], cmd_hits[6] + cmd_hits[7]);
        $display("checked %0d output words, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
